/* hw/rtl/p1305_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package p1305_pkg;

  // Limb arithmetic: radix 2^26, five limbs
  localparam int N_LIMBS   = 5;
  localparam int LIMB_W    = 26;
  localparam int HW        = 27;            // stored accumulator limb, limb 1 may carry a bit
  localparam int AW        = 28;            // accumulator limb plus message limb
  localparam int R5W       = 29;            // clamped r limb times five
  localparam int PROD_W    = AW + R5W;      // one lane product
  localparam int DW        = PROD_W + 4;    // column sum plus incoming carry
  localparam int CW        = 32;            // carry word, wraps like a 32-bit register
  localparam int DATA_W    = 128;
  localparam int BLK_W     = DATA_W + 1;    // message block with its pad bit
  localparam int CNT_W     = 5;
  localparam int KEY_W     = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] FULL_BLOCK_BYTES = 5'd16;

  localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
  localparam logic [CW-1:0]     LIMB_MASK32 = 32'h03ffffff;
  localparam logic [CW-1:0]     LIMB_WRAP32 = 32'h04000000;

  // Clamp masks for the r limbs, limb 4 first
  localparam logic [N_LIMBS-1:0][LIMB_W-1:0] R_CLAMP = {
    26'h00fffff, 26'h3f03fff, 26'h3ffc0ff, 26'h3ffff03, 26'h3ffffff
  };

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_R_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_S_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_S_HIGH = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] r_low;
    logic [KEY_W-1:0] r_high;
    logic [KEY_W-1:0] s_low;
    logic [KEY_W-1:0] s_high;
  } key_t;

  // One unit of work handed from the front end to the back end
  typedef struct packed {
    logic             absorb;
    logic             last;
    logic [BLK_W-1:0] blk;
  } entry_t;

  typedef logic [N_LIMBS-1:0][HW-1:0] hlimbs_t;

endpackage

`default_nettype wire

/* hw/rtl/poly1305_authenticator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Poly1305 one-time authenticator. The 32-byte one-time key is loaded through
// the register port as four 64-bit words: r low, r high, s low, s high (r is
// clamped as it is used, so the raw key bytes may be written). Each transfer on
// the input stream carries one message block of up to 16 bytes, little-endian,
// with its byte count; only the final block of a message may be short, and a
// final transfer with a count of zero closes a message without adding data (on
// its own it yields s, the tag of the empty message). When tlast is set, the
// 16-byte tag follows as one transfer on the output stream and the accumulator
// is cleared for the next message. A front end pads and classifies each block
// and places it in a two-entry queue, so the input keeps accepting while the
// queue has room, also while the back end works and while a tag waits to be
// taken. The back end handles one block at a time: it adds the block to the
// accumulator, runs the limb multiply column by column through five 28x29-bit
// multiplier lanes and folds the top carry back. A final block then passes
// through a carry round, the subtraction of the prime where the value reaches
// it and the addition of s before the tag appears. Keys must be written only
// while the block is idle. No clearing pass is needed after reset.
module poly1305_authenticator #(
  parameter int QUEUE_DEPTH = p1305_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,

  // Key register port
  input  logic                            cfg_wr_en,
  input  logic [p1305_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [p1305_pkg::KEY_W-1:0]     cfg_data,

  // Message blocks
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata from bit 0: block_low [63:0], block_high [127:64],
  // byte_count [132:128], zero fill [135:133]
  input  logic [135:0]                    s_tdata,
  input  logic                            s_tlast,

  // Tags
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata from bit 0: tag_low [63:0], tag_high [127:64]
  output logic [p1305_pkg::DATA_W-1:0]    m_tdata
);
  import p1305_pkg::*;

  key_t   key;
  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_valid;

  // Key registers; writes to them are taken on any cycle with the enable set.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_R_LOW:  key.r_low  <= cfg_data;
        CFG_R_HIGH: key.r_high <= cfg_data;
        CFG_S_LOW:  key.s_low  <= cfg_data;
        CFG_S_HIGH: key.s_high <= cfg_data;
      endcase
    end
  end

  // The front end pads the block and drops empty blocks that close nothing.
  p1305_front u_front (
    .block      (s_tdata[DATA_W-1:0]),
    .byte_count (s_tdata[DATA_W +: CNT_W]),
    .last       (s_tlast),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry)
  );

  p1305_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .full     (q_full),
    .valid    (q_valid),
    .rd_entry (head_entry)
  );

  // The back end owns the accumulator, the multiplier lanes and the tag register.
  p1305_back u_back (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .q_valid   (q_valid),
    .q_entry   (head_entry),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/p1305_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module p1305_front (
  input  logic [p1305_pkg::DATA_W-1:0] block,
  input  logic [p1305_pkg::CNT_W-1:0]  byte_count,
  input  logic                         last,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         q_full,
  output logic                         push,
  output p1305_pkg::entry_t            entry
);
  import p1305_pkg::*;

  logic [CNT_W-1:0] count;
  logic [7:0]       shift;
  logic [BLK_W-1:0] pad_bit;
  logic [BLK_W-1:0] keep_mask;

  // Bytes beyond the count are dropped and a one bit goes just above the data.
  // A full block therefore gets its pad at bit 128.
  always_comb begin
    count        = (byte_count > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : byte_count;
    shift        = {count, 3'b000};
    pad_bit      = BLK_W'(1) << shift;
    keep_mask    = pad_bit - BLK_W'(1);
    entry.blk    = ({1'b0, block} & keep_mask) | pad_bit;
    entry.absorb = (count != '0);
    entry.last   = last;
  end

  // An empty block that is not last changes nothing and is dropped here.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && (entry.absorb || last);

endmodule

`default_nettype wire

/* hw/rtl/p1305_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module p1305_queue #(
  parameter int DEPTH = p1305_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  p1305_pkg::entry_t wr_entry,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output p1305_pkg::entry_t rd_entry
);
  import p1305_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] fill;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign full     = (fill == CNTW'(DEPTH));
  assign valid    = (fill != '0);
  assign rd_entry = slots[rd_ptr];

endmodule

`default_nettype wire

/* hw/rtl/p1305_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module p1305_back (
  input  logic                         clk,
  input  logic                         rst,
  input  p1305_pkg::key_t              key,
  input  logic                         q_valid,
  input  p1305_pkg::entry_t            q_entry,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [p1305_pkg::DATA_W-1:0] out_data
);
  import p1305_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_FIN_A = 3'd3;
  localparam logic [2:0] ST_FIN_B = 3'd4;
  localparam logic [2:0] ST_FIN_C = 3'd5;

  logic [2:0]                      state;
  logic [2:0]                      col;
  logic                            last_q;
  hlimbs_t                         h;
  hlimbs_t                         h_fold;
  hlimbs_t                         fa;
  logic [DATA_W-1:0]               hh;
  logic [N_LIMBS-1:0][AW-1:0]      a;
  logic [N_LIMBS-1:0][LIMB_W-1:0]  hn;
  logic [N_LIMBS-1:0][PROD_W-1:0]  prod;
  logic [CW-1:0]                   carry;
  logic [N_LIMBS*LIMB_W-1:0]       r_wide;
  logic [N_LIMBS*LIMB_W-1:0]       blk_wide;
  logic [N_LIMBS-1:0][LIMB_W-1:0]  r;
  logic [N_LIMBS-1:0][R5W-1:0]     r5;
  logic [N_LIMBS-1:0][R5W-1:0]     mul_op;
  logic [DW-1:0]                   col_sum;
  logic [CW-1:0]                   fold_c5;
  logic [CW-1:0]                   fold_t;
  logic                            out_free;

  // First carry round of the final reduction, on 32-bit words.
  function automatic hlimbs_t carry_round(input hlimbs_t hin);
    logic [N_LIMBS-1:0][CW-1:0] t;
    logic [CW-1:0]              c;
    hlimbs_t                    res;
    for (int i = 0; i < N_LIMBS; i++) begin
      t[i] = CW'(hin[i]);
    end
    c = t[1] >> LIMB_W; t[1] = t[1] & LIMB_MASK32; t[2] = t[2] + c;
    c = t[2] >> LIMB_W; t[2] = t[2] & LIMB_MASK32; t[3] = t[3] + c;
    c = t[3] >> LIMB_W; t[3] = t[3] & LIMB_MASK32; t[4] = t[4] + c;
    c = t[4] >> LIMB_W; t[4] = t[4] & LIMB_MASK32; t[0] = t[0] + {c[CW-3:0], 2'b00} + c;
    c = t[0] >> LIMB_W; t[0] = t[0] & LIMB_MASK32; t[1] = t[1] + c;
    for (int i = 0; i < N_LIMBS; i++) begin
      res[i] = t[i][HW-1:0];
    end
    return res;
  endfunction

  // Subtract the prime where the value reaches it, then pack to 128 bits.
  function automatic logic [DATA_W-1:0] pack_reduced(input hlimbs_t hin);
    logic [N_LIMBS-1:0][CW-1:0] t;
    logic [N_LIMBS-1:0][CW-1:0] g;
    logic [N_LIMBS-1:0][CW-1:0] u;
    logic [CW-1:0]              c;
    logic                       take_g;
    for (int i = 0; i < N_LIMBS; i++) begin
      t[i] = CW'(hin[i]);
    end
    c = CW'(5);
    for (int i = 0; i < N_LIMBS - 1; i++) begin
      g[i] = t[i] + c;
      c    = g[i] >> LIMB_W;
      g[i] = g[i] & LIMB_MASK32;
    end
    g[4]   = t[4] + c - LIMB_WRAP32;
    take_g = !g[4][CW-1];
    for (int i = 0; i < N_LIMBS; i++) begin
      u[i] = take_g ? g[i] : t[i];
    end
    return {(u[3] >> 18) | (u[4] << 8),
            (u[2] >> 12) | (u[3] << 14),
            (u[1] >> 6)  | (u[2] << 20),
            u[0]         | (u[1] << 26)};
  endfunction

  assign r_wide   = {2'b00, key.r_high, key.r_low};
  assign blk_wide = {1'b0, q_entry.blk};

  always_comb begin
    for (int i = 0; i < N_LIMBS; i++) begin
      r[i]  = r_wide[i*LIMB_W +: LIMB_W] & R_CLAMP[i];
      r5[i] = R5W'({r[i], 2'b00}) + R5W'(r[i]);
    end
  end

  // Lane j of column col multiplies limb j by r[col-j], or by 5*r[col-j+5]
  // where the index wraps round the modulus.
  always_comb begin
    for (int j = 0; j < N_LIMBS; j++) begin
      logic [2:0] k;
      k = col - 3'(j);
      if (col >= 3'(j)) begin
        mul_op[j] = (k < 3'(N_LIMBS)) ? R5W'(r[k]) : '0;
      end else begin
        k = col + 3'(N_LIMBS) - 3'(j);
        mul_op[j] = r5[k];
      end
    end
  end

  always_comb begin
    col_sum = DW'(carry);
    for (int j = 0; j < N_LIMBS; j++) begin
      col_sum = col_sum + DW'(prod[j]);
    end
  end

  // Fold the top carry back into limb 0 with the factor five.
  always_comb begin
    fold_c5 = {carry[CW-3:0], 2'b00} + carry;
    fold_t  = CW'(hn[0]) + fold_c5;
    for (int i = 0; i < N_LIMBS; i++) begin
      h_fold[i] = HW'(hn[i]);
    end
    h_fold[0] = HW'(fold_t[LIMB_W-1:0]);
    h_fold[1] = HW'(hn[1]) + HW'(fold_t[CW-1:LIMB_W]);
  end

  assign pop      = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      last_q    <= 1'b0;
      h         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN_C && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            last_q <= q_entry.last;
            col    <= '0;
            state  <= q_entry.absorb ? ST_MUL : ST_FIN_A;
          end
        end
        ST_MUL: begin
          col <= col + 1'b1;
          if (col == 3'(N_LIMBS)) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          h     <= h_fold;
          state <= last_q ? ST_FIN_A : ST_IDLE;
        end
        ST_FIN_A: begin
          state <= ST_FIN_B;
        end
        ST_FIN_B: begin
          h     <= '0;
          state <= ST_FIN_C;
        end
        ST_FIN_C: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      carry <= '0;
      for (int i = 0; i < N_LIMBS; i++) begin
        a[i] <= AW'(h[i]) + AW'(blk_wide[i*LIMB_W +: LIMB_W]);
      end
    end
    if (state == ST_MUL) begin
      if (col < 3'(N_LIMBS)) begin
        for (int j = 0; j < N_LIMBS; j++) begin
          prod[j] <= PROD_W'(a[j]) * PROD_W'(mul_op[j]);
        end
      end
      if (col != '0) begin
        hn[3'(col - 3'd1)] <= col_sum[LIMB_W-1:0];
        carry              <= col_sum[LIMB_W +: CW];
      end
    end
    if (state == ST_FIN_A) begin
      fa <= carry_round(h);
    end
    if (state == ST_FIN_B) begin
      hh <= pack_reduced(fa);
    end
    if (state == ST_FIN_C && out_free) begin
      out_data <= hh + {key.s_high, key.s_low};
    end
  end

  a_block_reaches_fold: assert property (@(posedge clk) disable iff (rst)
    (pop && q_entry.absorb) |-> ##7 (state == ST_FOLD))
    else $error("absorbed block did not reach the fold step on time");

  a_acc_cleared_after_tag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN_B) |=> (h == '0))
    else $error("accumulator not cleared after final reduction");

  a_tag_presented: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN_C && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("tag not presented after final step");

  a_upper_limbs_narrow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (h[2][HW-1] == 1'b0 && h[3][HW-1] == 1'b0 &&
                            h[4][HW-1] == 1'b0))
    else $error("accumulator limbs two to four left unreduced");

endmodule

`default_nettype wire
